@@ src/sgspi_pkg.sv @@
package sgspi_pkg;

    // Fixed-point formats.
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int FACTOR_FRAC_BITS = 8;

    // Field and datapath widths.
    localparam int IN_W     = 20;
    localparam int ERR_W    = IN_W + 1;
    localparam int GAIN_W   = 16;
    localparam int FACTOR_W = FACTOR_FRAC_BITS + 1;
    localparam int KPS_W    = GAIN_W + FACTOR_W;
    localparam int P_W      = ERR_W + KPS_W;
    localparam int LO_W     = P_W / 2;
    localparam int HI_W     = P_W - LO_W;
    localparam int MUL_W    = KPS_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int LPROD_W  = LO_W + GAIN_W;
    localparam int HPROD_W  = HI_W + GAIN_W + 1;
    localparam int FULL_W   = P_W + GAIN_W + 1;
    localparam int SH_I     = 2 * GAIN_FRAC_BITS + FACTOR_FRAC_BITS;
    localparam int STEP_W   = FULL_W - SH_I;
    localparam int SUM_W    = STEP_W + 1;
    localparam int INT_W    = ANGLE_FRAC_BITS + 2;
    localparam int TOT_W    = P_W + 1;
    localparam int SH_P     = GAIN_FRAC_BITS + FACTOR_FRAC_BITS;
    localparam int SH_C     = ANGLE_FRAC_BITS + SH_P;
    localparam int CMD_W    = TOT_W - SH_C + 1;
    localparam int OUT_W    = 16;

    // APB register map.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_KP = 1'b0;
    localparam logic REG_KI = 1'b1;
    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(3840);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(256);

    // Error band thresholds, rounded up, and integral limits, rounded down.
    localparam int ONE_ANGLE = 1 << ANGLE_FRAC_BITS;
    localparam logic [ERR_W-1:0] TH_DEAD  = ERR_W'((ONE_ANGLE + 199) / 200);
    localparam logic [ERR_W-1:0] TH_BAND1 = ERR_W'((ONE_ANGLE + 19) / 20);
    localparam logic [ERR_W-1:0] TH_BAND2 = ERR_W'((ONE_ANGLE + 9) / 10);
    localparam logic [ERR_W-1:0] TH_BAND3 = ERR_W'((ONE_ANGLE + 4) / 5);

    localparam logic [INT_W-1:0] LIMIT_B0 = INT_W'((ONE_ANGLE * 4) / 10);
    localparam logic [INT_W-1:0] LIMIT_B1 = INT_W'((ONE_ANGLE * 7) / 10);
    localparam logic [INT_W-1:0] LIMIT_B2 = INT_W'((ONE_ANGLE * 9) / 10);
    localparam logic [INT_W-1:0] LIMIT_B3 = INT_W'(ONE_ANGLE);

    localparam logic [FACTOR_W-1:0] FACTOR_B0 = FACTOR_W'(128);
    localparam logic [FACTOR_W-1:0] FACTOR_B1 = FACTOR_W'(179);
    localparam logic [FACTOR_W-1:0] FACTOR_B2 = FACTOR_W'(230);
    localparam logic [FACTOR_W-1:0] FACTOR_B3 = FACTOR_W'(1 << FACTOR_FRAC_BITS);

    localparam logic signed [CMD_W-1:0] CMD_MAX = CMD_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [CMD_W-1:0] CMD_MIN = -CMD_W'(1 << (OUT_W - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAND,
        ST_KPS,
        ST_PERR,
        ST_PLO,
        ST_PHI,
        ST_STEP,
        ST_INTEG,
        ST_CMD,
        ST_DONE
    } state_t;

endpackage

@@ src/sgspi_mul.sv @@
module sgspi_mul (
    input  logic                                  aclk,
    input  logic signed [sgspi_pkg::MUL_W-1:0]    op_a,
    input  logic signed [sgspi_pkg::MUL_W-1:0]    op_b,
    output logic signed [sgspi_pkg::PROD_W-1:0]   prod
);

    logic signed [sgspi_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ src/sgspi_regs.sv @@
module sgspi_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sgspi_pkg::ADDR_W-1:0]        paddr,
    input  logic [sgspi_pkg::DATA_W-1:0]        pwdata,
    output logic [sgspi_pkg::DATA_W-1:0]        prdata,
    output logic [sgspi_pkg::GAIN_W-1:0]        kp,
    output logic [sgspi_pkg::GAIN_W-1:0]        ki
);

    logic [sgspi_pkg::GAIN_W-1:0] kp_reg;
    logic [sgspi_pkg::GAIN_W-1:0] ki_reg;
    logic                         wr_en;
    logic                         reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[sgspi_pkg::REG_SEL_BIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= sgspi_pkg::KP_RESET;
            ki_reg <= sgspi_pkg::KI_RESET;
        end else if (wr_en) begin
            if (reg_sel == sgspi_pkg::REG_KP) begin
                kp_reg <= pwdata[sgspi_pkg::GAIN_W-1:0];
            end else begin
                ki_reg <= pwdata[sgspi_pkg::GAIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == sgspi_pkg::REG_KP) begin
            prdata = sgspi_pkg::DATA_W'(kp_reg);
        end else begin
            prdata = sgspi_pkg::DATA_W'(ki_reg);
        end
    end

    assign kp = kp_reg;
    assign ki = ki_reg;

endmodule

@@ src/steer_gain_scheduled_pi.sv @@
// Gain-scheduled PI steering controller with deadband.
// Input channel (s_): one item per control tick carries the target and measured
// steering angles in signed Q7.12 radians. Result channel (m_): one item per
// input item with the motor drive command, a deadband flag and a saturation flag.
// Kp and Ki are written over the APB port (Kp at address 0, Ki at address 4) and
// should only change while the block is idle.
// An item is accepted only in the idle state. It then walks through a sequencer
// that uses one registered 26 x 26 multiplier four times (Kp times band factor,
// error times scaled Kp, then the two halves of the integral product), followed
// by the integral update and command rounding. When the output register is free,
// the result is loaded into it and the sequencer returns to idle, where the next
// item can be taken; no new item is taken while one is in progress. A deadband
// item skips the multiplier steps.
// If the receiver stalls, the finished result waits in the sequencer's last step
// until the output register is free; s_ready stays low meanwhile.
// Reset clears the integral, restores the default gains, and empties the output.
module steer_gain_scheduled_pi (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sgspi_pkg::ADDR_W-1:0]            paddr,
    input  logic [sgspi_pkg::DATA_W-1:0]            pwdata,
    output logic [sgspi_pkg::DATA_W-1:0]            prdata,
    output logic                                    pready,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [sgspi_pkg::IN_W-1:0]       s_target_angle,
    input  logic signed [sgspi_pkg::IN_W-1:0]       s_measured_angle,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [sgspi_pkg::OUT_W-1:0]      m_drive_command,
    output logic                                    m_in_deadband,
    output logic                                    m_command_saturated
);

    localparam int MUL_W   = sgspi_pkg::MUL_W;
    localparam int ERR_W   = sgspi_pkg::ERR_W;
    localparam int GAIN_W  = sgspi_pkg::GAIN_W;
    localparam int KPS_W   = sgspi_pkg::KPS_W;
    localparam int P_W     = sgspi_pkg::P_W;
    localparam int LO_W    = sgspi_pkg::LO_W;
    localparam int FULL_W  = sgspi_pkg::FULL_W;
    localparam int SUM_W   = sgspi_pkg::SUM_W;
    localparam int INT_W   = sgspi_pkg::INT_W;
    localparam int TOT_W   = sgspi_pkg::TOT_W;
    localparam int CMD_W   = sgspi_pkg::CMD_W;
    localparam int OUT_W   = sgspi_pkg::OUT_W;
    localparam int SH_I    = sgspi_pkg::SH_I;
    localparam int SH_C    = sgspi_pkg::SH_C;

    sgspi_pkg::state_t state_reg, state_next;

    logic [GAIN_W-1:0]                      kp;
    logic [GAIN_W-1:0]                      ki;
    logic signed [MUL_W-1:0]                op_a;
    logic signed [MUL_W-1:0]                op_b;
    logic signed [sgspi_pkg::PROD_W-1:0]    prod;

    logic signed [ERR_W-1:0]                err_reg;
    logic [sgspi_pkg::FACTOR_W-1:0]         factor_reg;
    logic [INT_W-1:0]                       limit_reg;
    logic                                   dead_reg;
    logic signed [P_W-1:0]                  p_reg;
    logic [sgspi_pkg::LPROD_W-1:0]          lo_prod_reg;
    logic signed [FULL_W-1:0]               full_reg;
    logic signed [INT_W-1:0]                integral_reg;
    logic signed [TOT_W-1:0]                total_reg;

    logic                                   m_valid_reg;
    logic signed [OUT_W-1:0]                m_drive_command_reg;
    logic                                   m_in_deadband_reg;
    logic                                   m_command_saturated_reg;

    logic [ERR_W-1:0]                       mag;
    logic                                   out_free;
    logic                                   step_corr;
    logic signed [SUM_W-1:0]                sum;
    logic signed [SUM_W-1:0]                lim_pos;
    logic signed [SUM_W-1:0]                lim_neg;
    logic signed [INT_W-1:0]                integ_clamped;
    logic                                   cmd_corr;
    logic signed [CMD_W-1:0]                cmd_full;
    logic signed [OUT_W-1:0]                cmd_sat;
    logic                                   cmd_clip;

    sgspi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .kp      (kp),
        .ki      (ki)
    );

    sgspi_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == sgspi_pkg::ST_IDLE);

    assign mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);

    // Integral step: truncate the full product toward zero, add it, clamp.
    assign step_corr = full_reg[FULL_W-1] && (|full_reg[SH_I-1:0]);
    assign sum = SUM_W'(integral_reg) + SUM_W'($signed(full_reg[FULL_W-1:SH_I]))
               + SUM_W'(step_corr);
    assign lim_pos = $signed(SUM_W'(limit_reg));
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (sum > lim_pos) begin
            integ_clamped = INT_W'(lim_pos);
        end else if (sum < lim_neg) begin
            integ_clamped = INT_W'(lim_neg);
        end else begin
            integ_clamped = INT_W'(sum);
        end
    end

    // Command: truncate toward zero to an integer, then saturate.
    assign cmd_corr = total_reg[TOT_W-1] && (|total_reg[SH_C-1:0]);
    assign cmd_full = CMD_W'($signed(total_reg[TOT_W-1:SH_C])) + CMD_W'(cmd_corr);

    always_comb begin
        priority if (cmd_full > sgspi_pkg::CMD_MAX) begin
            cmd_sat  = OUT_W'(sgspi_pkg::CMD_MAX);
            cmd_clip = 1'b1;
        end else if (cmd_full < sgspi_pkg::CMD_MIN) begin
            cmd_sat  = OUT_W'(sgspi_pkg::CMD_MIN);
            cmd_clip = 1'b1;
        end else begin
            cmd_sat  = OUT_W'(cmd_full);
            cmd_clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgspi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            sgspi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sgspi_pkg::ST_BAND;
                end
            end
            sgspi_pkg::ST_BAND: begin
                if (mag < sgspi_pkg::TH_DEAD) begin
                    state_next = sgspi_pkg::ST_DONE;
                end else begin
                    state_next = sgspi_pkg::ST_KPS;
                end
            end
            sgspi_pkg::ST_KPS: begin
                op_a = $signed(MUL_W'(kp));
                op_b = $signed(MUL_W'(factor_reg));
                state_next = sgspi_pkg::ST_PERR;
            end
            sgspi_pkg::ST_PERR: begin
                op_a = MUL_W'(err_reg);
                op_b = $signed(MUL_W'(prod[KPS_W-1:0]));
                state_next = sgspi_pkg::ST_PLO;
            end
            sgspi_pkg::ST_PLO: begin
                op_a = $signed(MUL_W'(prod[LO_W-1:0]));
                op_b = $signed(MUL_W'(ki));
                state_next = sgspi_pkg::ST_PHI;
            end
            sgspi_pkg::ST_PHI: begin
                op_a = MUL_W'($signed(p_reg[P_W-1:LO_W]));
                op_b = $signed(MUL_W'(ki));
                state_next = sgspi_pkg::ST_STEP;
            end
            sgspi_pkg::ST_STEP: begin
                state_next = sgspi_pkg::ST_INTEG;
            end
            sgspi_pkg::ST_INTEG: begin
                state_next = sgspi_pkg::ST_CMD;
            end
            sgspi_pkg::ST_CMD: begin
                state_next = sgspi_pkg::ST_DONE;
            end
            sgspi_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sgspi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sgspi_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers, loaded step by step as the sequencer advances.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            sgspi_pkg::ST_IDLE: begin
                err_reg <= ERR_W'(s_target_angle) - ERR_W'(s_measured_angle);
            end
            sgspi_pkg::ST_BAND: begin
                dead_reg <= (mag < sgspi_pkg::TH_DEAD);
                priority if (mag < sgspi_pkg::TH_BAND1) begin
                    factor_reg <= sgspi_pkg::FACTOR_B0;
                    limit_reg  <= sgspi_pkg::LIMIT_B0;
                end else if (mag < sgspi_pkg::TH_BAND2) begin
                    factor_reg <= sgspi_pkg::FACTOR_B1;
                    limit_reg  <= sgspi_pkg::LIMIT_B1;
                end else if (mag < sgspi_pkg::TH_BAND3) begin
                    factor_reg <= sgspi_pkg::FACTOR_B2;
                    limit_reg  <= sgspi_pkg::LIMIT_B2;
                end else begin
                    factor_reg <= sgspi_pkg::FACTOR_B3;
                    limit_reg  <= sgspi_pkg::LIMIT_B3;
                end
            end
            sgspi_pkg::ST_PLO: begin
                p_reg <= prod[P_W-1:0];
            end
            sgspi_pkg::ST_PHI: begin
                lo_prod_reg <= prod[sgspi_pkg::LPROD_W-1:0];
            end
            sgspi_pkg::ST_STEP: begin
                full_reg <= (FULL_W'($signed(prod[sgspi_pkg::HPROD_W-1:0])) <<< LO_W)
                          + $signed(FULL_W'(lo_prod_reg));
            end
            sgspi_pkg::ST_CMD: begin
                total_reg <= TOT_W'(p_reg) + (TOT_W'(integral_reg) <<< sgspi_pkg::SH_P);
            end
            default: begin
            end
        endcase
    end

    // The integral is cleared by reset and in the deadband.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
        end else if (state_reg == sgspi_pkg::ST_BAND && mag < sgspi_pkg::TH_DEAD) begin
            integral_reg <= '0;
        end else if (state_reg == sgspi_pkg::ST_INTEG) begin
            integral_reg <= integ_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == sgspi_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sgspi_pkg::ST_DONE && out_free) begin
            m_drive_command_reg     <= dead_reg ? '0 : cmd_sat;
            m_in_deadband_reg       <= dead_reg;
            m_command_saturated_reg <= !dead_reg && cmd_clip;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_drive_command     = m_drive_command_reg;
    assign m_in_deadband       = m_in_deadband_reg;
    assign m_command_saturated = m_command_saturated_reg;

endmodule
